/* rtl/pprt_pkg.sv */
// ----------------------------------------------------------------------------
// pprt_pkg: shared types and codes for the peer priority response table
// Holds the command codes, the field widths and the request token that
// travels along the chain of table cells.
// ----------------------------------------------------------------------------
package pprt_pkg;

  localparam int CMD_W   = 3;
  localparam int ID_W    = 32;
  localparam int COUNT_W = 5;

  // Command codes; the two unused codes behave as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_MARK   = 3'd3,
    CMD_SWEEP  = 3'd4,
    CMD_QUERY  = 3'd5
  } cmd_t;

  // Request token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             done;
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  node_id;
    logic             higher_flag;
  } tok_t;

endpackage

/* rtl/pprt_if.sv */
// ----------------------------------------------------------------------------
// pprt_if: request and response channels of the peer priority table
// Valid/ready channels; a transfer happens when valid and ready are high
// at the same rising clock edge.
// ----------------------------------------------------------------------------
interface pprt_req_if;
  logic                       valid;
  logic                       ready;
  logic [pprt_pkg::CMD_W-1:0] command;
  logic [pprt_pkg::ID_W-1:0]  node_id;
  logic                       higher_flag;

  modport source (output valid, command, node_id, higher_flag, input ready);
  modport sink   (input valid, command, node_id, higher_flag, output ready);
endinterface

interface pprt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pprt_pkg::COUNT_W-1:0] waiting_ahead;
  logic                         all_higher;
  logic [pprt_pkg::COUNT_W-1:0] entries_used;
  logic                         dropped;

  modport source (output valid, waiting_ahead, all_higher, entries_used, dropped,
                  input ready);
  modport sink   (input valid, waiting_ahead, all_higher, entries_used, dropped,
                  output ready);
endinterface

/* rtl/pprt_cell.sv */
// ----------------------------------------------------------------------------
// pprt_cell: one slot of the peer priority table
// Holds one entry, applies the passing request to it, adds its own state
// to the running counts and hands the request to the next cell.
// ----------------------------------------------------------------------------
module pprt_cell #(
  parameter int CW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  pprt_pkg::tok_t   tok_in,
  input  logic [CW-1:0]    used_in,
  input  logic [CW-1:0]    wait_in,
  output pprt_pkg::tok_t   tok_out,
  output logic [CW-1:0]    used_out,
  output logic [CW-1:0]    wait_out
);

  logic                      ent_valid;
  logic                      ent_valid_next;
  logic [pprt_pkg::ID_W-1:0] ent_node;
  logic [pprt_pkg::ID_W-1:0] ent_node_next;
  logic                      ent_higher;
  logic                      ent_higher_next;
  logic                      ent_seen;
  logic                      ent_seen_next;
  logic                      done_next;
  logic                      match;
  pprt_pkg::tok_t            tok_next;

  // Apply the request to this slot
  always_comb begin
    ent_valid_next  = ent_valid;
    ent_node_next   = ent_node;
    ent_higher_next = ent_higher;
    ent_seen_next   = ent_seen;
    done_next       = tok_in.done;
    match           = ent_valid && (ent_node == tok_in.node_id);
    if (tok_in.valid) begin
      case (tok_in.command)
        pprt_pkg::CMD_INSERT: begin
          // claim the first free slot on the way
          if (!tok_in.done && !ent_valid) begin
            ent_valid_next  = 1'b1;
            ent_node_next   = tok_in.node_id;
            ent_higher_next = tok_in.higher_flag;
            ent_seen_next   = 1'b0;
            done_next       = 1'b1;
          end
        end
        pprt_pkg::CMD_UPDATE: begin
          // only the first matching slot takes the new flag
          if (!tok_in.done && match) begin
            ent_higher_next = tok_in.higher_flag;
            done_next       = 1'b1;
          end
        end
        pprt_pkg::CMD_REMOVE: begin
          if (match) begin
            ent_valid_next = 1'b0;
            ent_seen_next  = 1'b0;
          end
        end
        pprt_pkg::CMD_MARK: begin
          if (match) begin
            ent_seen_next = 1'b1;
          end
        end
        pprt_pkg::CMD_SWEEP: begin
          if (ent_valid && !ent_seen) begin
            ent_valid_next = 1'b0;
          end
          ent_seen_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // pass the request on with its updated done mark
    tok_next      = tok_in;
    tok_next.done = done_next;
  end

  // Hold control state and the request register
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid     <= 1'b0;
      ent_seen      <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      ent_valid <= ent_valid_next;
      ent_seen  <= ent_seen_next;
      tok_out   <= tok_next;
    end
  end

  // Advance entry payload and the running counts
  always_ff @(posedge clk) begin
    if (advance) begin
      ent_node   <= ent_node_next;
      ent_higher <= ent_higher_next;
      used_out   <= used_in + CW'(ent_valid_next);
      wait_out   <= wait_in + CW'(ent_valid_next && !ent_higher_next);
    end
  end

endmodule

/* rtl/peer_priority_response_table_core.sv */
// ----------------------------------------------------------------------------
// peer_priority_response_table_core: table of peer score responses
// A row of table cells that a request walks through, one cell a cycle while the row is not held.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (command, node_id, higher_flag); rsp returns one
//   summary per request (waiting_ahead, all_higher, entries_used, dropped).
//   A request enters the first cell when accepted and moves one cell per
//   cycle while the row is not held; the summary is counted on the way and
//   registered on rsp when the request leaves the last cell. An update that
//   finds no matching identifier walks the row a second time as an insert.
//   One request is in the row at a time: req is ready again once the
//   summary is loaded, so a new request is taken only after the last one
//   has finished its walk along the row of cells.
//   Reset empties the table and clears all seen marks at once.
//   While rsp is stalled a finished summary holds in its register and a
//   new request is still taken; a second finished summary holds the row.
// ----------------------------------------------------------------------------
module peer_priority_response_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  pprt_req_if.sink  req,
  pprt_rsp_if.source rsp
);

  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = CW + pprt_pkg::COUNT_W;

  pprt_pkg::tok_t tok      [TABLE_DEPTH+1];
  logic [CW-1:0]  used_cnt [TABLE_DEPTH+1];
  logic [CW-1:0]  wait_cnt [TABLE_DEPTH+1];

  logic             busy;
  logic             out_valid;
  logic             advance;
  logic             recirc;
  logic             finish;
  logic             accept;
  logic [EXT_W-1:0] used_ext;
  logic [EXT_W-1:0] wait_ext;

  logic [pprt_pkg::COUNT_W-1:0] waiting_ahead;
  logic                         all_higher;
  logic [pprt_pkg::COUNT_W-1:0] entries_used;
  logic                         dropped;

  // Handshake and row control
  assign recirc  = tok[TABLE_DEPTH].valid && !tok[TABLE_DEPTH].done &&
                   (tok[TABLE_DEPTH].command == pprt_pkg::CMD_UPDATE);
  assign advance = !(tok[TABLE_DEPTH].valid && !recirc && out_valid && !rsp.ready);
  assign finish  = tok[TABLE_DEPTH].valid && !recirc && advance;
  assign req.ready = !busy;
  assign accept  = req.valid && !busy;

  // Feed the first cell: a missed update returns as an insert
  always_comb begin
    tok[0]      = '0;
    used_cnt[0] = '0;
    wait_cnt[0] = '0;
    if (recirc) begin
      tok[0]         = tok[TABLE_DEPTH];
      tok[0].command = pprt_pkg::CMD_INSERT;
    end else if (accept) begin
      tok[0].valid       = 1'b1;
      tok[0].done        = 1'b0;
      tok[0].command     = req.command;
      tok[0].node_id     = req.node_id;
      tok[0].higher_flag = req.higher_flag;
    end
  end

  // Row of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pprt_cell #(.CW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .tok_in   (tok[i]),
      .used_in  (used_cnt[i]),
      .wait_in  (wait_cnt[i]),
      .tok_out  (tok[i+1]),
      .used_out (used_cnt[i+1]),
      .wait_out (wait_cnt[i+1])
    );
  end

  assign used_ext = EXT_W'(used_cnt[TABLE_DEPTH]);
  assign wait_ext = EXT_W'(wait_cnt[TABLE_DEPTH]);

  // Track the request in flight and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the summary
  always_ff @(posedge clk) begin
    if (finish) begin
      waiting_ahead <= wait_ext[pprt_pkg::COUNT_W-1:0];
      all_higher    <= (wait_cnt[TABLE_DEPTH] == '0);
      entries_used  <= used_ext[pprt_pkg::COUNT_W-1:0];
      dropped       <= !tok[TABLE_DEPTH].done &&
                       (tok[TABLE_DEPTH].command == pprt_pkg::CMD_INSERT);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.waiting_ahead = waiting_ahead;
  assign rsp.all_higher    = all_higher;
  assign rsp.entries_used  = entries_used;
  assign rsp.dropped       = dropped;

endmodule

/* rtl/pprt_chk.sv */
// ----------------------------------------------------------------------------
// pprt_chk: port-level checks for the peer priority response table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module pprt_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [pprt_pkg::COUNT_W-1:0] rsp_waiting_ahead,
  input logic                         rsp_all_higher,
  input logic [pprt_pkg::COUNT_W-1:0] rsp_entries_used
);

  // One request in the row at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in the row");

  // Summary flag agrees with the count
  a_all_higher: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_all_higher == (rsp_waiting_ahead == '0)))
    else $error("all_higher disagrees with waiting_ahead");

  // An empty table has nobody waiting
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_entries_used == '0) |-> rsp_all_higher)
    else $error("empty table reports a waiting peer");

  // Stalled response stays valid and keeps its entries_used
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entries_used))
    else $error("stalled response changed");

endmodule

bind peer_priority_response_table_core pprt_chk u_pprt_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_waiting_ahead (rsp.waiting_ahead),
  .rsp_all_higher    (rsp.all_higher),
  .rsp_entries_used  (rsp.entries_used)
);
